[hw/rtl/msa_pkg.sv]
// Package with the word types and the cell link type of the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

    // Width of one sorted value.
    localparam int unsigned VALUE_W = 8;

    // Input word: one element of the stream.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } msa_in_t;

    // Output word: one element of the ascending run.
    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               end_of_run;
        logic               overflow;
    } msa_out_t;

    // What a cell shows to its neighbours.
    typedef struct packed {
        logic               valid;
        logic               gt;
        logic [VALUE_W-1:0] value;
    } msa_link_t;

endpackage

`default_nettype wire

[hw/rtl/msa_cell.sv]
// One cell of the insertion chain: holds one value, compares, shifts and drains.
`timescale 1ns / 1ps
`default_nettype none

module msa_cell
    import msa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               insert_en,
    input  wire logic               drain_en,
    input  wire logic [VALUE_W-1:0] ins_value,
    input  wire msa_link_t          prev_link,
    input  wire msa_link_t          next_link,
    output msa_link_t               link
);

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               gt;

    // The held value is greater than the value being inserted.
    assign gt = valid_reg && (value_reg > ins_value);

    // During insertion a cell either takes its left neighbour's displaced
    // value, takes the new value at the insertion point, or keeps its own.
    // During draining every value moves one cell towards the output.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (drain_en)
        begin
            valid_next = next_link.valid;
            value_next = next_link.value;
        end
        else if (insert_en)
        begin
            if (prev_link.gt)
            begin
                valid_next = 1'b1;
                value_next = prev_link.value;
            end
            else if (prev_link.valid && (!valid_reg || gt))
            begin
                valid_next = 1'b1;
                value_next = ins_value;
            end
        end
    end

    // The valid bit is control state; the value needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

`default_nettype wire

[hw/rtl/merge_and_sort_ascending_core.sv]
// Top level of the insertion sorter: a chain of CAPACITY cells and the drain control.
// A word is inserted in the cycle it is accepted, or dropped if the chain is full.
// After the word marked last is accepted, the run appears from the next cycle, smallest first,
// one word per cycle while result_ready is high.
// One word per cycle is taken, but input is held off while a run drains.
// Reset clears every cell's valid bit, the overflow flag and the drain state; the chain is empty.
`timescale 1ns / 1ps
`default_nettype none

module merge_and_sort_ascending_core
    import msa_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire msa_in_t  item,
    output logic          result_valid,
    input  wire logic     result_ready,
    output msa_out_t      result
);

    msa_link_t links [CAPACITY];

    logic draining_reg;
    logic draining_next;
    logic dropped_reg;
    logic dropped_next;
    logic item_acc;
    logic result_acc;
    logic full;
    logic insert_en;
    logic drain_en;

    // Handshakes and chain control.
    assign item_ready   = !draining_reg;
    assign item_acc     = item_valid && item_ready;
    assign result_valid = draining_reg && links[0].valid;
    assign result_acc   = result_valid && result_ready;
    assign full         = links[CAPACITY-1].valid;
    assign insert_en    = item_acc && !full;
    assign drain_en     = result_acc;

    // The chain of cells; cell 0 holds the smallest value.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        msa_link_t prev_link;
        msa_link_t next_link;

        if (i == 0)
        begin : g_first
            assign prev_link = '{valid: 1'b1, gt: 1'b0, value: '0};
        end
        else
        begin : g_mid
            assign prev_link = links[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign next_link = '{valid: 1'b0, gt: 1'b0, value: '0};
        end
        else
        begin : g_inner
            assign next_link = links[i+1];
        end

        msa_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .insert_en (insert_en),
            .drain_en  (drain_en),
            .ins_value (item.value),
            .prev_link (prev_link),
            .next_link (next_link),
            .link      (links[i])
        );
    end

    // Drain state and overflow flag.
    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (item_acc && item.last)
        begin
            draining_next = 1'b1;
        end
        if (item_acc && full)
        begin
            dropped_next = 1'b1;
        end
        if (result_acc && !links[1].valid)
        begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    // The output value comes straight from the head cell; end_of_run shows that cell 1 is empty.
    assign result.sorted_value = links[0].value;
    assign result.end_of_run   = !links[1].valid;
    assign result.overflow     = dropped_reg;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the ascending insertion sorter core.
`timescale 1ns / 1ps

module tb_top;
    import msa_pkg::*;

    localparam int unsigned STORE_DEPTH    = 32;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_SETTLE   = STORE_DEPTH + 8;

    // Value patterns used to fill one set.
    typedef enum int {
        FILL_ANY,
        FILL_NARROW,
        FILL_EXTREMES
    } fill_mode_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     item_valid   = 1'b0;
    logic     item_ready;
    msa_in_t  item         = '0;
    logic     result_valid;
    logic     result_ready = 1'b0;
    msa_out_t result;

    // Idling percentages for the current phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Predicted state of the sorter and the words still due from it.
    logic [VALUE_W-1:0] sorted_store [STORE_DEPTH];
    int                 store_fill    = 0;
    logic               store_dropped = 1'b0;
    msa_out_t           expected_run [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int items_sent     = 0;

    merge_and_sort_ascending_core #(
        .CAPACITY (STORE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Insert one accepted value into the predicted store; on the last mark, queue the run.
    task automatic predict_sort(input logic [VALUE_W-1:0] v, input logic is_last);
        int       pos;
        int       k;
        msa_out_t w;
        if (store_fill < STORE_DEPTH)
        begin
            pos = store_fill;
            while (pos > 0 && sorted_store[pos-1] > v)
            begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = v;
            store_fill++;
        end
        else
        begin
            store_dropped = 1'b1;
        end
        if (is_last)
        begin
            for (k = 0; k < store_fill; k++)
            begin
                w.sorted_value = sorted_store[k];
                w.end_of_run   = (k + 1 == store_fill);
                w.overflow     = store_dropped;
                expected_run.push_back(w);
            end
            store_fill    = 0;
            store_dropped = 1'b0;
        end
    endtask

    // Present one word, hold it until it is taken, then update the prediction.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic is_last);
        msa_in_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        w.value    = v;
        w.last     = is_last;
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_sort(v, is_last);
        items_sent++;
    endtask

    // Hold the input off until every predicted word has come out.
    task automatic wait_run_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_run.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input fill_mode_t mode);
        case (mode)
            FILL_NARROW:   pick_value = VALUE_W'($urandom_range(3));
            FILL_EXTREMES: pick_value = $urandom_range(1) ? 8'hFF : 8'h00;
            default:       pick_value = VALUE_W'($urandom_range(255));
        endcase
    endfunction

    // Send a whole set of the given length with the last mark on its final word.
    task automatic send_set(input int len, input fill_mode_t mode);
        int i;
        for (i = 0; i < len; i++)
            send_word(pick_value(mode), i == len - 1);
    endtask

    // Sets of one at both ends and in the middle of the value range.
    task automatic test_single_sets();
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h80, 1'b1);
    endtask

    // Unordered values with duplicates, alternating bit patterns and both extremes.
    task automatic test_order_and_duplicates();
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b1);
        wait_run_drained();
    endtask

    // Fill the store, drop two plain words, then drop the last word too; the run still comes.
    task automatic test_store_full();
        int i;
        for (i = 0; i < STORE_DEPTH; i++)
            send_word(VALUE_W'(STORE_DEPTH - i), 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h7F, 1'b1);
        // The next set must start with a clear overflow flag.
        send_word(8'h10, 1'b0);
        send_word(8'h0F, 1'b1);
    endtask

    // Random sets, mostly short, some filling or overrunning the store.
    task automatic test_random_sets(input int idle_pct, input int stall_pct, input int quota);
        int         start;
        int         len;
        int         r;
        fill_mode_t mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = items_sent;
        while (items_sent - start < quota)
        begin
            r = $urandom_range(99);
            if (r < 75)
                len = $urandom_range(12, 1);
            else if (r < 90)
                len = $urandom_range(31, 13);
            else
                len = $urandom_range(40, 32);
            r = $urandom_range(99);
            mode = (r < 70) ? FILL_ANY : (r < 85) ? FILL_NARROW : FILL_EXTREMES;
            send_set(len, mode);
            if ($urandom_range(99) < 10)
                wait_run_drained();
        end
        wait_run_drained();
    endtask

    // Result side: compare each taken word with the oldest prediction, then pick the next ready.
    always @(posedge clk)
    begin
        msa_out_t want;
        if (result_valid && result_ready)
        begin
            if (expected_run.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: word with no prediction waiting, actual %h", $time, result);
            end
            else
            begin
                want = expected_run.pop_front();
                if (result.sorted_value !== want.sorted_value)
                begin
                    mismatch_count++;
                    $display("%0t: sorted_value expected %0d, actual %0d",
                             $time, want.sorted_value, result.sorted_value);
                end
                if (result.end_of_run !== want.end_of_run)
                begin
                    mismatch_count++;
                    $display("%0t: end_of_run expected %b, actual %b",
                             $time, want.end_of_run, result.end_of_run);
                end
                if (result.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    $display("%0t: overflow expected %b, actual %b",
                             $time, want.overflow, result.overflow);
                end
            end
        end
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sets();
        test_order_and_duplicates();
        test_store_full();
        test_random_sets(0, 0, 90);
        test_random_sets(51, 0, 90);
        test_random_sets(0, 51, 90);
        test_random_sets(32, 32, 90);

        item_valid <= 1'b0;
        while (expected_run.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
